[hw/rtl/multi_motor_encoder_unwrap_defines.svh]
// Assertion macros shared by the multi-motor encoder unwrap RTL.
// No dependencies; include by bare file name.
`ifndef MULTI_MOTOR_ENCODER_UNWRAP_DEFINES_SVH
`define MULTI_MOTOR_ENCODER_UNWRAP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define MMEU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define MMEU_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MMEU_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define MMEU_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

[hw/rtl/mmeu_pkg.sv]
// Package for the multi-motor encoder unwrap: widths, reset values,
// register indexes and the payload struct types. No dependencies.
`timescale 1ns / 1ps

package mmeu_pkg;

    // Field widths
    localparam int ID_W       = 11;
    localparam int ANGLE_W    = 13;
    localparam int SPEED_W    = 16;
    localparam int CURRENT_W  = 16;
    localparam int TEMP_W     = 8;
    localparam int POS_W      = 32;
    localparam int TURN_W     = 20;
    localparam int WARMUP_W   = 16;

    // Motors and counts per revolution (power of two, applied as a shift)
    localparam int MOTOR_COUNT = 4;
    localparam int MOTOR_IDX_W = 2;
    localparam int REV_SHIFT   = 13;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_BASE_ID   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_JUMP_THR  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WARMUP    = 2'd2;

    localparam logic [ID_W-1:0]     BASE_ID_RST  = 11'd513;
    localparam logic [ANGLE_W-1:0]  JUMP_THR_RST = 13'd6000;
    localparam logic [WARMUP_W-1:0] WARMUP_RST   = 16'd1000;

    typedef struct packed {
        logic [ID_W-1:0]             frame_id;
        logic [ANGLE_W-1:0]          angle_raw;
        logic signed [SPEED_W-1:0]   speed_raw;
        logic signed [CURRENT_W-1:0] current_raw;
        logic [TEMP_W-1:0]           temperature_raw;
    } in_item_t;

    typedef struct packed {
        logic                        matched;
        logic [MOTOR_IDX_W-1:0]      motor_index;
        logic                        calibrating;
        logic signed [POS_W-1:0]     position;
        logic signed [TURN_W-1:0]    turn_count_out;
        logic signed [SPEED_W-1:0]   speed_out;
        logic signed [CURRENT_W-1:0] current_out;
        logic [TEMP_W-1:0]           temperature_out;
    } out_item_t;

endpackage

[hw/rtl/multi_motor_encoder_unwrap.sv]
// Multi-motor encoder unwrap: offset capture during warm-up, then turn
// tracking and position unwrap per motor. Depends on mmeu_pkg and the defines header.
`timescale 1ns / 1ps
`include "multi_motor_encoder_unwrap_defines.svh"

// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    in_item_t  (one feedback frame)
// m_        out        m_valid/m_ready    out_item_t (one result per frame)
// cfg_      in         cfg_wen            cfg_addr, cfg_wdata (no wait)
//
// A frame enters an input register, is processed combinationally (id match,
// angle step compare, turn update, position add) and lands in a result
// register: one frame per cycle sustained while m_ready stays high. Per-motor
// state updates at the processing edge, so a following frame sees it.
// Synchronous active-low reset clears configuration to defaults and all
// motor state to zero. A stalled result holds; input still fills its register.
module multi_motor_encoder_unwrap
    import mmeu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wen,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers
    logic [ID_W-1:0]     base_id_reg;
    logic [ANGLE_W-1:0]  jump_thr_reg;
    logic [WARMUP_W-1:0] warmup_frames_reg;

    // Block state
    logic [WARMUP_W-1:0] warm_cnt_reg;
    logic [ANGLE_W-1:0]  last_angle_reg  [MOTOR_COUNT];
    logic [ANGLE_W-1:0]  zero_offset_reg [MOTOR_COUNT];
    logic [TURN_W-1:0]   turn_count_reg  [MOTOR_COUNT];
    logic [POS_W-1:0]    last_pos_reg    [MOTOR_COUNT];

    // Pipeline registers
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    // Processing signals
    logic                   proc;
    logic [WARMUP_W-1:0]    warm_cnt_next;
    logic                   cal;
    logic [ID_W:0]          id_diff;
    logic                   hit;
    logic [MOTOR_IDX_W-1:0] idx;
    logic signed [ANGLE_W+1:0] step;
    logic signed [ANGLE_W+1:0] thr;
    logic                   wrap_dn;
    logic                   wrap_up;
    logic [TURN_W-1:0]      turn_next;
    logic [POS_W-1:0]       pos_next;
    out_item_t              out_next;

    // Advance a frame when the result register is free or being drained
    assign proc    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Saturating warm-up counter and calibration flag
    always_comb begin
        if (warm_cnt_reg < warmup_frames_reg) begin
            warm_cnt_next = warm_cnt_reg + 1'b1;
        end else begin
            warm_cnt_next = warmup_frames_reg;
        end
        cal = warm_cnt_next < warmup_frames_reg;
    end

    // Match the frame id against the four motor ids
    always_comb begin
        id_diff = {1'b0, in_data_reg.frame_id} - {1'b0, base_id_reg};
        hit     = !id_diff[ID_W] && (id_diff < (ID_W+1)'(MOTOR_COUNT));
        idx     = id_diff[MOTOR_IDX_W-1:0];
    end

    // Detect a revolution wrap from the angle step and update the turn count
    always_comb begin
        step = (ANGLE_W+2)'({1'b0, in_data_reg.angle_raw})
             - (ANGLE_W+2)'({1'b0, last_angle_reg[idx]});
        thr     = (ANGLE_W+2)'({1'b0, jump_thr_reg});
        wrap_dn = step > thr;
        wrap_up = step < -thr;
        if (wrap_dn) begin
            turn_next = turn_count_reg[idx] - 1'b1;
        end else if (wrap_up) begin
            turn_next = turn_count_reg[idx] + 1'b1;
        end else begin
            turn_next = turn_count_reg[idx];
        end
        pos_next = {turn_next[POS_W-REV_SHIFT-1:0], {REV_SHIFT{1'b0}}}
                 + POS_W'(in_data_reg.angle_raw)
                 - POS_W'(zero_offset_reg[idx]);
    end

    // Assemble the result; an unmatched frame reports only the warm-up status
    always_comb begin
        out_next             = '0;
        out_next.calibrating = cal;
        if (hit) begin
            out_next.matched         = 1'b1;
            out_next.motor_index     = idx;
            out_next.position        = cal ? last_pos_reg[idx] : pos_next;
            out_next.turn_count_out  = cal ? turn_count_reg[idx] : turn_next;
            out_next.speed_out       = in_data_reg.speed_raw;
            out_next.current_out     = in_data_reg.current_raw;
            out_next.temperature_out = in_data_reg.temperature_raw;
        end
    end

    // Control, configuration and motor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_id_reg       <= BASE_ID_RST;
            jump_thr_reg      <= JUMP_THR_RST;
            warmup_frames_reg <= WARMUP_RST;
            warm_cnt_reg      <= '0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                last_angle_reg[k]  <= '0;
                zero_offset_reg[k] <= '0;
                turn_count_reg[k]  <= '0;
                last_pos_reg[k]    <= '0;
            end
        end else begin
            if (cfg_wen) begin
                case (cfg_addr)
                    REG_BASE_ID:  base_id_reg       <= cfg_wdata[ID_W-1:0];
                    REG_JUMP_THR: jump_thr_reg      <= cfg_wdata[ANGLE_W-1:0];
                    REG_WARMUP:   warmup_frames_reg <= cfg_wdata[WARMUP_W-1:0];
                    default: ;
                endcase
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proc) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (proc) begin
                warm_cnt_reg <= warm_cnt_next;
                if (hit) begin
                    last_angle_reg[idx] <= in_data_reg.angle_raw;
                    if (cal) begin
                        zero_offset_reg[idx] <= in_data_reg.angle_raw;
                    end else begin
                        turn_count_reg[idx] <= turn_next;
                        last_pos_reg[idx]   <= pos_next;
                    end
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (proc) begin
            out_data_reg <= out_next;
        end
    end

    // Checks
    `MMEU_ASSERT_IMP(a_unmatched_zero, aclk, aresetn, m_valid && !m_data.matched, m_data.position == '0 && m_data.turn_count_out == '0, "unmatched result carries motor data")
    `MMEU_ASSERT_NXT(a_warm_sat, aclk, aresetn, proc && !cfg_wen, warm_cnt_reg <= warmup_frames_reg, "warm-up counter above limit")
    `MMEU_ASSERT_NXT(a_proc_loads, aclk, aresetn, proc, out_valid_reg, "processed frame lost")
    `MMEU_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !out_valid_reg, s_ready, "input stalled with empty output")

endmodule

[verif/tb.sv]
// Self-checking testbench for multi_motor_encoder_unwrap: directed and random feedback
// frames, a tracking predictor in a small scoreboard class, random bursts and stalls.
// Depends on mmeu_pkg and the multi_motor_encoder_unwrap RTL.
`timescale 1ns / 1ps

module tb;
    import mmeu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_FRAMES = 1400;
    localparam int PRINT_CAP = 60;
    // Index with no register behind it; writes there must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_pattern_e;

    // Tracks warm-up, offsets and turns per motor and holds the results still owed
    class unwrap_board;
        logic [ID_W-1:0]     base_id;
        logic [ANGLE_W-1:0]  jump_thr;
        logic [WARMUP_W-1:0] warmup_frames;
        logic [WARMUP_W-1:0] warmup_count;
        logic [ANGLE_W-1:0]  last_angle [MOTOR_COUNT];
        logic [ANGLE_W-1:0]  zero_offset [MOTOR_COUNT];
        logic [TURN_W-1:0]   turns [MOTOR_COUNT];
        logic [POS_W-1:0]    last_pos [MOTOR_COUNT];
        out_item_t           unwrap_results [$];
        int                  mismatches;

        function new();
            base_id       = BASE_ID_RST;
            jump_thr      = JUMP_THR_RST;
            warmup_frames = WARMUP_RST;
            warmup_count  = '0;
            mismatches    = 0;
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                last_angle[k]  = '0;
                zero_offset[k] = '0;
                turns[k]       = '0;
                last_pos[k]    = '0;
            end
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_BASE_ID:  base_id = data[ID_W-1:0];
                REG_JUMP_THR: jump_thr = data[ANGLE_W-1:0];
                REG_WARMUP:   warmup_frames = data[WARMUP_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return unwrap_results.size();
        endfunction

        // Advance the per-motor state by one frame and queue the result it owes
        function void note_frame(in_item_t f);
            out_item_t r;
            logic      cal;
            int        id_i, base_i, idx, ang_i, prev_i, thr_i, step;
            logic [POS_W-1:0] pos;

            if (warmup_count < warmup_frames) warmup_count = warmup_count + 1'b1;
            else warmup_count = warmup_frames;
            cal = (warmup_count < warmup_frames);

            r = '0;
            r.calibrating = cal;
            id_i   = f.frame_id;
            base_i = base_id;
            idx    = id_i - base_i;
            if (idx >= 0 && idx < MOTOR_COUNT) begin
                if (cal) begin
                    // capture the zero offset, position and turns stay as stored
                    zero_offset[idx] = f.angle_raw;
                    last_angle[idx]  = f.angle_raw;
                end else begin
                    ang_i  = f.angle_raw;
                    prev_i = last_angle[idx];
                    thr_i  = jump_thr;
                    step   = ang_i - prev_i;
                    if (step > thr_i) turns[idx] = turns[idx] - 1'b1;
                    else if (step < -thr_i) turns[idx] = turns[idx] + 1'b1;
                    last_angle[idx] = f.angle_raw;
                    pos = {{(POS_W-TURN_W){turns[idx][TURN_W-1]}}, turns[idx]};
                    pos = (pos << REV_SHIFT) + POS_W'(f.angle_raw) - POS_W'(zero_offset[idx]);
                    last_pos[idx] = pos;
                end
                r.matched         = 1'b1;
                r.motor_index     = idx[MOTOR_IDX_W-1:0];
                r.position        = last_pos[idx];
                r.turn_count_out  = turns[idx];
                r.speed_out       = f.speed_raw;
                r.current_out     = f.current_raw;
                r.temperature_out = f.temperature_raw;
            end
            unwrap_results.push_back(r);
        endfunction

        task report(string field, longint want_v, longint got_v);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("mismatch at %0t: %s expected %0d got %0d",
                         $realtime, field, want_v, got_v);
        endtask

        // Compare one result transfer with the oldest owed result
        task check_result(out_item_t got);
            out_item_t want;
            if (unwrap_results.size() == 0) begin
                report("result with no frame pending", 0, 0);
                return;
            end
            want = unwrap_results.pop_front();
            if (got.matched !== want.matched)
                report("matched", want.matched, got.matched);
            if (got.motor_index !== want.motor_index)
                report("motor_index", want.motor_index, got.motor_index);
            if (got.calibrating !== want.calibrating)
                report("calibrating", want.calibrating, got.calibrating);
            if (got.position !== want.position)
                report("position", want.position, got.position);
            if (got.turn_count_out !== want.turn_count_out)
                report("turn_count_out", want.turn_count_out, got.turn_count_out);
            if (got.speed_out !== want.speed_out)
                report("speed_out", want.speed_out, got.speed_out);
            if (got.current_out !== want.current_out)
                report("current_out", want.current_out, got.current_out);
            if (got.temperature_out !== want.temperature_out)
                report("temperature_out", want.temperature_out, got.temperature_out);
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wen = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    unwrap_board board;
    int          burst_left = 0;
    int          cur_angle [MOTOR_COUNT] = '{default: 0};
    rx_pattern_e rx_pattern = RX_OPEN;
    int          rx_left = 0;
    int          rx_phase = 0;

    multi_motor_encoder_unwrap i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Stall the result channel on a random pattern that is redrawn at random intervals
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_pattern <= rx_pattern_e'($urandom_range(0, 3));
            rx_left <= $urandom_range(8, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_pattern)
            RX_OPEN:     m_ready <= 1'b1;
            RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_ready <= ((rx_phase % 5) < 2);
            RX_SPARSE:   m_ready <= ($urandom_range(0, 5) == 0);
            default:     m_ready <= 1'b1;
        endcase
    end

    // Watch both channels; values seen here are the ones the edge samples
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_frame(s_data);
            if (m_valid && m_ready) board.check_result(m_data);
        end
    end

    initial begin
        for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge aclk);
        $display("tb: FAIL");
        $finish;
    end

    function automatic in_item_t make_frame(input int id, input int ang);
        in_item_t f;
        f.frame_id        = id[ID_W-1:0];
        f.angle_raw       = ang[ANGLE_W-1:0];
        f.speed_raw       = SPEED_W'($urandom);
        f.current_raw     = CURRENT_W'($urandom);
        f.temperature_raw = TEMP_W'($urandom);
        return f;
    endfunction

    // Hold the frame until its transfer, opening a random gap between bursts
    task automatic send_frame(input in_item_t f);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= f;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_fixed(input int id, input int ang, input int spd, input int cur,
                              input int temp);
        in_item_t f;
        f = make_frame(id, ang);
        f.speed_raw       = spd[SPEED_W-1:0];
        f.current_raw     = cur[CURRENT_W-1:0];
        f.temperature_raw = temp[TEMP_W-1:0];
        send_frame(f);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        board.set_reg(addr, data);
    endtask

    // Write all registers plus the spare index; noisy sets the unused upper bits
    task automatic apply_settings(input int base, input int thr, input int warm,
                                  input bit noisy);
        logic [CFG_DATA_W-1:0] junk;
        junk = noisy ? CFG_DATA_W'($urandom) : '0;
        write_reg(REG_BASE_ID, CFG_DATA_W'(base) | (junk & 16'hF800));
        write_reg(REG_JUMP_THR, CFG_DATA_W'(thr) | (junk & 16'hE000));
        write_reg(REG_WARMUP, CFG_DATA_W'(warm));
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_wen <= 1'b0;
    endtask

    // Drop valid, let the last input transfer be noted, then wait until every
    // owed result has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
    endtask

    // One setting, then mostly smooth motion per motor with jumps, boundary steps and noise
    task automatic run_tracking_phase(input int count);
        int base, thr, warm, kind, k, id, ang, s;
        case ($urandom_range(0, 7))
            0:       base = 0;
            1:       base = 2047 - $urandom_range(0, 2);
            default: base = $urandom_range(0, 2047);
        endcase
        case ($urandom_range(0, 7))
            0:       thr = 0;
            1:       thr = 8191;
            default: thr = $urandom_range(3000, 7000);
        endcase
        case ($urandom_range(0, 9))
            0:       warm = 1;
            1:       warm = 65535;
            2:       warm = $urandom_range(100, 3000);
            default: warm = $urandom_range(1, 40);
        endcase
        apply_settings(base, thr, warm, 1'b1);
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 19);
            k = $urandom_range(0, MOTOR_COUNT - 1);
            id = (base + k) & 2047;
            if (kind < 2) begin
                id  = $urandom_range(0, 2047);
                ang = $urandom_range(0, 8191);
            end else if (kind < 4) begin
                ang = $urandom_range(0, 8191);
            end else if (kind < 6) begin
                // step right at the threshold or one past it
                s = thr + $urandom_range(0, 1);
                if ($urandom_range(0, 1) == 1 && cur_angle[k] + s <= 8191)
                    ang = cur_angle[k] + s;
                else if (cur_angle[k] >= s)
                    ang = cur_angle[k] - s;
                else if (cur_angle[k] + s <= 8191)
                    ang = cur_angle[k] + s;
                else
                    ang = $urandom_range(0, 8191);
            end else begin
                ang = (cur_angle[k] + $urandom_range(0, 3000) - 1500) & 8191;
            end
            if (kind >= 2) cur_angle[k] = ang;
            send_frame(make_frame(id, ang));
        end
        drain();
    endtask

    initial begin
        int sent;
        int n;
        board = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Lowest base id, widest threshold, short warm-up; field extremes
        apply_settings(0, 8191, 3, 1'b0);
        send_fixed(0, 0, 0, 0, 0);
        send_fixed(3, 8191, -32768, 32767, 255);
        send_fixed(2047, 1234, 1, -1, 128);
        send_fixed(0, 8191, 32767, -32768, 0);
        send_fixed(4, 0, -1, 1, 255);
        send_fixed(3, 0, 0, 0, 1);
        drain();

        // Zero warm-up lowers the counter and tracks at once; top ids, zero threshold
        apply_settings(2046, 0, 0, 1'b0);
        send_fixed(2046, 5, 100, -100, 20);
        send_fixed(2047, 0, -200, 200, 30);
        send_fixed(2045, 77, 0, 0, 40);
        send_fixed(2046, 5, 1, 1, 50);
        send_fixed(2046, 6, 2, 2, 60);
        drain();

        // Default base, longest warm-up for capture, then warm-up cut below the counter
        apply_settings(513, 6000, 65535, 1'b0);
        send_fixed(513, 100, 10, 10, 10);
        send_fixed(514, 8191, 11, 11, 11);
        send_fixed(515, 0, 12, 12, 12);
        send_fixed(516, 4096, 13, 13, 13);
        send_fixed(517, 4096, 14, 14, 14);
        drain();
        apply_settings(513, 6000, 2, 1'b0);
        send_fixed(513, 8000, 20, 20, 20);
        send_fixed(513, 50, 21, 21, 21);
        send_fixed(513, 6150, 22, 22, 22);
        send_fixed(513, 150, 23, 23, 23);
        drain();

        sent = 0;
        while (sent < RANDOM_FRAMES) begin
            n = $urandom_range(60, 140);
            run_tracking_phase(n);
            sent += n;
        end

        repeat (8) @(posedge aclk);
        if (board.mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
